// ===== rtl/swmf_pkg.sv =====
// Shared constants and types for the sliding window median filter.
package swmf_pkg;

	localparam int MAX_HALF_DEF    = 7;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int HALF_WIDTH_BITS = 3;

	localparam logic [HALF_WIDTH_BITS-1:0] HALF_WIDTH_RESET = 3'd1;

	typedef struct packed {
		logic shift;
		logic clear;
		logic load;
	} win_ctl_t;

endpackage

// ===== rtl/swmf_cell.sv =====
// One window cell: sample, valid bit, ordering against the other cells, rank match.
module swmf_cell import swmf_pkg::*; #(
	parameter int DEPTH       = 2 * MAX_HALF_DEF + 1,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int RW         = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  win_ctl_t                      ctl,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          valid_in,
	input  logic [DEPTH-1:0]              order_in,
	input  logic signed [SAMPLE_BITS-1:0] probe,
	input  logic [DEPTH-1:0]              mask,
	input  logic                          in_window,
	input  logic [RW-1:0]                 target,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          valid_out,
	output logic [DEPTH-1:0]              order_out,
	output logic                          lt,
	output logic signed [SAMPLE_BITS-1:0] pick
);

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [DEPTH-1:0]              order_q;
	logic                          valid_q;
	logic [RW-1:0]                 rank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= valid_in;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			sample_q <= sample_in;
			order_q  <= order_in;
		end
	end

	// count window cells that sort ahead of this one
	always_comb begin
		rank = '0;
		for (int j = 0; j < DEPTH; j++) begin
			rank = rank + RW'(order_q[j] & mask[j]);
		end
	end

	assign lt         = sample_q < probe;
	assign pick       = (in_window && rank == target) ? sample_q : '0;
	assign sample_out = sample_q;
	assign valid_out  = valid_q;
	assign order_out  = order_q;

endmodule

// ===== rtl/swmf_seq.sv =====
// Sequencer: half width register, stream count, result scheduling and output handshake.
module swmf_seq import swmf_pkg::*; #(
	parameter int MAX_HALF = MAX_HALF_DEF,
	localparam int DEPTH   = 2 * MAX_HALF + 1,
	localparam int LW      = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       half_width_valid,
	input  logic [HALF_WIDTH_BITS-1:0] half_width,
	input  logic                       sample_valid,
	input  logic                       last,
	output logic                       sample_stall,
	input  logic                       filtered_stall,
	output logic                       filtered_valid,
	output logic                       last_res,
	output win_ctl_t                   ctl,
	output logic [LW-1:0]              lim
);

	localparam int HW = $clog2(MAX_HALF + 1);
	localparam int CW = $clog2(MAX_HALF + 2);

	logic [HALF_WIDTH_BITS-1:0] half_width_q;
	logic [CW-1:0]              cnt_q;
	logic                       pend_q;
	logic                       flush_q;
	logic                       out_valid_q;
	logic                       out_last_q;
	logic [LW-1:0]              lim_q;
	logic [LW-1:0]              lim_start;
	logic [HW-1:0]              h;
	logic                       out_free;
	logic                       emit;
	logic                       at_end;
	logic                       done;
	logic                       accept;
	logic                       need;

	always_comb begin
		if (int'(half_width_q) > MAX_HALF) begin
			h = HW'(MAX_HALF);
		end else begin
			h = HW'(half_width_q);
		end
	end

	assign out_free     = !out_valid_q || !filtered_stall;
	assign emit         = pend_q && out_free;
	assign at_end       = !flush_q || (lim_q == LW'(h));
	assign done         = emit && at_end;
	assign sample_stall = pend_q && !done;
	assign accept       = sample_valid && !sample_stall;
	assign need         = int'(cnt_q) >= int'(h);

	// final item starts at the oldest centre that holds a sample
	always_comb begin
		if (last && int'(cnt_q) < int'(h)) begin
			lim_start = LW'(int'(cnt_q) + int'(h));
		end else begin
			lim_start = LW'(2 * int'(h));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HALF_WIDTH_RESET;
			cnt_q        <= '0;
			pend_q       <= 1'b0;
			flush_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_last_q   <= 1'b0;
			lim_q        <= '0;
		end else begin
			if (half_width_valid) begin
				half_width_q <= half_width;
			end
			if (accept) begin
				pend_q  <= last || need;
				flush_q <= last;
				lim_q   <= lim_start;
				if (last) begin
					cnt_q <= '0;
				end else if (int'(cnt_q) < MAX_HALF + 1) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end else if (done) begin
				pend_q <= 1'b0;
			end else if (emit) begin
				lim_q <= lim_q - LW'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				out_last_q  <= flush_q && at_end;
			end else if (!filtered_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign ctl.shift      = accept;
	assign ctl.clear      = done && flush_q;
	assign ctl.load       = emit;
	assign lim            = lim_q;
	assign filtered_valid = out_valid_q;
	assign last_res       = out_last_q;

endmodule

// ===== rtl/sliding_window_median_filter.sv =====
// Top level of the sliding window median filter.
// Running median over a stream of signed samples: each result is the upper median of the
// samples from h before to h after one position, cut to what exists at either end of the
// stream, with h the half_width register clamped to MAX_HALF. A row of 2*MAX_HALF+1 cells
// holds the newest samples; each cell keeps the sort order of its sample against all others,
// updated by one compare per cell as a sample shifts in, so a median is a combinational rank
// match. A sample that is not marked last is accepted every cycle while the result side does
// not stall, and its result (once h+1 samples have arrived) passes the pending flag and then
// the result register. The marked last sample gives min(h, earlier samples of its stream) + 1
// flushed results and stalls the next item for all but the final one of them, since the
// shared rank and select path resolves one window per cycle while results drain. A stall on
// the result side holds the input once one item waits behind the result register.
module sliding_window_median_filter import swmf_pkg::*; #(
	parameter int MAX_HALF    = MAX_HALF_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          half_width_valid,
	output logic                          half_width_ready,
	input  logic [HALF_WIDTH_BITS-1:0]    half_width,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last,
	output logic                          filtered_valid,
	input  logic                          filtered_stall,
	output logic signed [SAMPLE_BITS-1:0] filtered,
	output logic                          last_res
);

	localparam int DEPTH = 2 * MAX_HALF + 1;
	localparam int LW    = $clog2(DEPTH);
	localparam int RW    = $clog2(DEPTH + 1);

	win_ctl_t                      ctl;
	logic [LW-1:0]                 lim;
	logic [DEPTH-1:0]              mask;
	logic [DEPTH-1:0]              cell_valid;
	logic [DEPTH-1:0]              lt;
	logic [RW-1:0]                 win_count;
	logic [RW-1:0]                 target;
	logic signed [SAMPLE_BITS-1:0] pick;
	logic signed [SAMPLE_BITS-1:0] filtered_q;
	logic signed [SAMPLE_BITS-1:0] cell_sample [DEPTH];
	logic signed [SAMPLE_BITS-1:0] cell_pick   [DEPTH];
	logic [DEPTH-1:0]              cell_order  [DEPTH];

	assign half_width_ready = 1'b1;

	swmf_seq #(
		.MAX_HALF(MAX_HALF)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.half_width_valid(half_width_valid),
		.half_width      (half_width),
		.sample_valid    (sample_valid),
		.last            (last),
		.sample_stall    (sample_stall),
		.filtered_stall  (filtered_stall),
		.filtered_valid  (filtered_valid),
		.last_res        (last_res),
		.ctl             (ctl),
		.lim             (lim)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic                          valid_in;
		logic [DEPTH-1:0]              order_in;

		assign mask[i] = cell_valid[i] && (LW'(i) <= lim);

		if (i == 0) begin : g_head
			assign sample_in = sample;
			assign valid_in  = 1'b1;
			assign order_in  = {lt[DEPTH-2:0], 1'b0};
		end else begin : g_body
			assign sample_in = cell_sample[i-1];
			assign valid_in  = cell_valid[i-1] & ~ctl.clear;
			assign order_in  = {cell_order[i-1][DEPTH-2:0], ~lt[i-1]};
		end

		swmf_cell #(
			.DEPTH      (DEPTH),
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.sample_in (sample_in),
			.valid_in  (valid_in),
			.order_in  (order_in),
			.probe     (sample),
			.mask      (mask),
			.in_window (mask[i]),
			.target    (target),
			.sample_out(cell_sample[i]),
			.valid_out (cell_valid[i]),
			.order_out (cell_order[i]),
			.lt        (lt[i]),
			.pick      (cell_pick[i])
		);
	end

	// upper median: rank floor(n/2) among the window cells
	always_comb begin
		win_count = '0;
		for (int j = 0; j < DEPTH; j++) begin
			win_count = win_count + RW'(mask[j]);
		end
		target = win_count >> 1;
	end

	always_comb begin
		pick = '0;
		for (int i = 0; i < DEPTH; i++) begin
			pick = pick | cell_pick[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			filtered_q <= pick;
		end
	end

	assign filtered = filtered_q;

endmodule
